// ===== sv/bc1_palette_interpolator_top_macros.svh =====
// ----------------------------------------------------------------------------
// bc1_palette_interpolator_top_macros
// Assertion shorthands shared by the palette interpolator checker.
// ----------------------------------------------------------------------------
`ifndef BC1_PALETTE_INTERPOLATOR_TOP_MACROS_SVH
`define BC1_PALETTE_INTERPOLATOR_TOP_MACROS_SVH

// same-cycle implication, off while reset is held
`define BC1PI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is held
`define BC1PI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bc1pi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1pi_pkg
// Shared codes, weights, types and helpers of the BC1 palette interpolator.
// ----------------------------------------------------------------------------
package bc1pi_pkg;

  // blend arithmetic selection
  localparam logic [1:0] BLEND_EXACT     = 2'd0;
  localparam logic [1:0] BLEND_EXACT_RND = 2'd1;
  localparam logic [1:0] BLEND_VENDOR_A  = 2'd2;
  localparam logic [1:0] BLEND_VENDOR_B  = 2'd3;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // first vendor weights on raw 5-bit channels and on 8-bit green
  localparam logic [10:0] VA_THIRD_W5 = 11'd22;
  localparam logic [10:0] VA_HALF_W5  = 11'd33;
  localparam logic signed [17:0] VA_THIRD_WG = 18'sd80;
  localparam logic signed [17:0] VA_HALF_WG  = 18'sd128;
  localparam logic signed [17:0] VA_ROUND    = 18'sd128;

  // second vendor weights
  localparam logic [14:0] VB_WA    = 15'd43;
  localparam logic [14:0] VB_WB    = 15'd21;
  localparam logic [14:0] VB_ROUND = 15'd32;

  typedef struct packed {
    logic        three_color;
    logic [31:0] entry3;
    logic [31:0] entry2;
    logic [31:0] entry1;
    logic [31:0] entry0;
  } palette_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // floor(x/3) for x up to 766 by reciprocal multiply
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

endpackage

// ===== sv/bc1_palette_interpolator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1_palette_interpolator_top
// BC1 color palette decoder: two RGB565 endpoints in, four RGBA8 entries out.
// ----------------------------------------------------------------------------
// Accepts one endpoint pair per clock unless the output stalls. The item sits
// in an input register, the palette logic (constant multiplies and a
// reciprocal divide by three) runs in one pass on it, and the palette is then
// captured in an output register and held there until taken. Sustained rate
// is one item per cycle; a stalled output backs up through the input register
// to in_tready. blend_mode is written through the cfg port and applies to the
// item in the input register but not to one already in the output register,
// so write it only while no item is in flight.
module bc1_palette_interpolator_top
  import bc1pi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // low_endpoint[15:0], high_endpoint[31:16]
  input  logic         in_tuser,   // allow_three_color[0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // palette_entry_zero[31:0], _one[63:32],
                                   // _two[95:64], _three[127:96]
  output logic         out_tuser,  // three_color_used[0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_data
);

  logic [1:0]  blend_mode_r;
  logic        in_valid_r;
  logic [15:0] low_r, high_r;
  logic        allow_r;
  logic        out_valid_r;
  palette_t    result_r;
  palette_t    palette;
  logic        out_adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_mode_r <= BLEND_EXACT;
    end else if (cfg_valid && cfg_ready) begin
      blend_mode_r <= cfg_data;
    end
  end

  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (out_adv) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_tready) begin
      low_r   <= in_tdata[15:0];
      high_r  <= in_tdata[31:16];
      allow_r <= in_tuser;
    end
    if (out_adv) begin
      result_r <= palette;
    end
  end

  bc1pi_palette u_palette (
    .blend_mode        (blend_mode_r),
    .low_endpoint      (low_r),
    .high_endpoint     (high_r),
    .allow_three_color (allow_r),
    .palette           (palette)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {result_r.entry3, result_r.entry2, result_r.entry1, result_r.entry0};
  assign out_tuser  = result_r.three_color;

endmodule

// ===== sv/bc1pi_entry_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1pi_entry_blend
// One blended palette entry from a source endpoint towards a target endpoint.
// ----------------------------------------------------------------------------
module bc1pi_entry_blend
  import bc1pi_pkg::*;
(
  input  logic [1:0]  blend_mode,
  input  logic [15:0] src,
  input  logic [15:0] dst,
  input  logic        half,
  output logic [31:0] entry
);

  logic [4:0] sr5, sb5, dr5, db5;
  logic [5:0] sg6, dg6;
  logic [7:0] r8, g8, b8;

  // 8-bit channel blend for the exact and second vendor modes
  function automatic logic [7:0] mix8(input logic [1:0] m, input logic [7:0] a,
                                      input logic [7:0] b, input logic h);
    logic [9:0]  tri_sum;
    logic [8:0]  pair_sum;
    logic [14:0] wsum;
    logic [7:0]  res;
    tri_sum  = {1'b0, a, 1'b0} + {2'b00, b};
    pair_sum = {1'b0, a} + {1'b0, b};
    wsum     = 15'(a) * VB_WA + 15'(b) * VB_WB + VB_ROUND;
    if (h) begin
      if (m == BLEND_VENDOR_B) begin
        res = 8'((pair_sum + 9'd1) >> 1);
      end else begin
        res = pair_sum[8:1];
      end
    end else begin
      case (m)
        BLEND_EXACT_RND: res = div3(tri_sum + 10'd1);
        BLEND_VENDOR_B:  res = wsum[13:6];
        default:         res = div3(tri_sum);
      endcase
    end
    return res;
  endfunction

  // first vendor red/blue on raw 5-bit values
  function automatic logic [7:0] vend5(input logic [4:0] a, input logic [4:0] b,
                                       input logic h);
    logic [10:0] p;
    if (h) begin
      p = 11'({1'b0, a} + {1'b0, b}) * VA_HALF_W5;
    end else begin
      p = 11'({1'b0, a, 1'b0} + {2'b00, b}) * VA_THIRD_W5;
    end
    return p[10:3];
  endfunction

  // first vendor green; quarter of the difference truncates toward zero
  function automatic logic [7:0] vendg(input logic [7:0] a, input logic [7:0] b,
                                       input logic h);
    logic signed [9:0]  d;
    logic signed [9:0]  dq;
    logic signed [17:0] w;
    logic signed [17:0] s;
    d  = $signed({2'b00, b}) - $signed({2'b00, a});
    dq = (d + (d[9] ? 10'sd3 : 10'sd0)) >>> 2;
    w  = h ? VA_HALF_WG : VA_THIRD_WG;
    s  = $signed({2'b00, a, 8'h00}) + 18'(dq) + VA_ROUND + 18'(d) * w;
    return s[17] ? 8'd0 : s[15:8];
  endfunction

  assign sr5 = src[15:11];
  assign sg6 = src[10:5];
  assign sb5 = src[4:0];
  assign dr5 = dst[15:11];
  assign dg6 = dst[10:5];
  assign db5 = dst[4:0];

  always_comb begin
    if (blend_mode == BLEND_VENDOR_A) begin
      r8 = vend5(sr5, dr5, half);
      g8 = vendg(widen6(sg6), widen6(dg6), half);
      b8 = vend5(sb5, db5, half);
    end else begin
      r8 = mix8(blend_mode, widen5(sr5), widen5(dr5), half);
      g8 = mix8(blend_mode, widen6(sg6), widen6(dg6), half);
      b8 = mix8(blend_mode, widen5(sb5), widen5(db5), half);
    end
  end

  assign entry = {ALPHA_OPAQUE, b8, g8, r8};

endmodule

// ===== sv/bc1pi_palette.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1pi_palette
// Full four-entry palette and mode choice from one endpoint pair.
// ----------------------------------------------------------------------------
module bc1pi_palette
  import bc1pi_pkg::*;
(
  input  logic [1:0]  blend_mode,
  input  logic [15:0] low_endpoint,
  input  logic [15:0] high_endpoint,
  input  logic        allow_three_color,
  output palette_t    palette
);

  logic        three;
  logic [31:0] blend_two;
  logic [31:0] blend_three;

  assign three = allow_three_color && (high_endpoint >= low_endpoint);

  bc1pi_entry_blend u_blend_two (
    .blend_mode (blend_mode),
    .src        (low_endpoint),
    .dst        (high_endpoint),
    .half       (three),
    .entry      (blend_two)
  );

  bc1pi_entry_blend u_blend_three (
    .blend_mode (blend_mode),
    .src        (high_endpoint),
    .dst        (low_endpoint),
    .half       (1'b0),
    .entry      (blend_three)
  );

  assign palette.entry0 = {ALPHA_OPAQUE, widen5(low_endpoint[4:0]),
                           widen6(low_endpoint[10:5]), widen5(low_endpoint[15:11])};
  assign palette.entry1 = {ALPHA_OPAQUE, widen5(high_endpoint[4:0]),
                           widen6(high_endpoint[10:5]), widen5(high_endpoint[15:11])};
  assign palette.entry2 = blend_two;
  // transparent black in three-color mode
  assign palette.entry3 = three ? 32'd0 : blend_three;
  assign palette.three_color = three;

endmodule

// ===== sv/bc1pi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1pi_checker
// Port-level checks of the palette interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bc1_palette_interpolator_top_macros.svh"

module bc1pi_checker
  import bc1pi_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic         out_tuser
);

  `BC1PI_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled item changed")
  `BC1PI_ASSERT_NOW(a_endpoints_opaque, out_tvalid, out_tdata[31:24] == ALPHA_OPAQUE && out_tdata[63:56] == ALPHA_OPAQUE && out_tdata[95:88] == ALPHA_OPAQUE, "endpoint or blend entry not opaque")
  `BC1PI_ASSERT_NOW(a_three_black, out_tvalid && out_tuser, out_tdata[127:96] == 32'd0, "three-color entry three not transparent black")
  `BC1PI_ASSERT_NOW(a_four_opaque, out_tvalid && !out_tuser, out_tdata[127:120] == ALPHA_OPAQUE, "four-color entry three not opaque")
  `BC1PI_ASSERT_NOW(a_three_order, out_tvalid && out_tuser, {out_tdata[39:35], out_tdata[47:42], out_tdata[55:51]} >= {out_tdata[7:3], out_tdata[15:10], out_tdata[23:19]}, "three-color chosen with high below low")

endmodule

bind bc1_palette_interpolator_top bc1pi_checker u_bc1pi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/tb_bc1_palette_interpolator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bc1_palette_interpolator_top
// Self-checking bench for the BC1 palette interpolator.
// ----------------------------------------------------------------------------
// Drives endpoint pairs into the input stream and rebuilds each palette in
// the bench from the endpoints and the current blend mode. Every palette that
// leaves the block is checked, entry by entry, against the oldest one still
// owed. Covers all four blend modes, three-color selection, equal and
// swapped endpoints, random idle on both stream sides, and a long output
// stall that backs the block up into its input.
module tb_bc1_palette_interpolator_top;
  import bc1pi_pkg::*;

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata   = '0;   // low_endpoint[15:0], high_endpoint[31:16]
  logic         in_tuser   = 1'b0; // allow_three_color[0]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;         // entry zero[31:0], one[63:32], two[95:64],
                                   // three[127:96]
  logic         out_tuser;         // three_color_used[0]
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_data   = '0;

  logic [1:0]   active_mode = BLEND_EXACT;
  palette_t     palettes_owed[$];
  int           error_count  = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           stall_left    = 0;

  bc1_palette_interpolator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int scale5(input int v);
    return ((v << 3) | (v >> 2)) & 255;
  endfunction

  function automatic int scale6(input int v);
    return ((v << 2) | (v >> 4)) & 255;
  endfunction

  // blend of two 8-bit channels for the exact and second vendor modes
  function automatic int blend8(input int a, input int b, input bit half);
    if (half) begin
      if (active_mode == BLEND_VENDOR_B) return (a + b + 1) >> 1;
      return (a + b) >> 1;
    end
    case (active_mode)
      BLEND_EXACT_RND: return (2 * a + b + 1) / 3;
      BLEND_VENDOR_B:  return (a * 43 + b * 21 + 32) >> 6;
      default:         return (2 * a + b) / 3;
    endcase
  endfunction

  // first vendor green; division truncates toward zero as in hardware
  function automatic int vendor_green(input int a, input int b, input int w);
    int d;
    int s;
    d = b - a;
    s = 256 * a + d / 4 + 128 + d * w;
    if (s < 0) s = 0;
    return (s >> 8) & 255;
  endfunction

  // color blended from endpoint a towards endpoint b, RGBA8 packed
  function automatic logic [31:0] blend_color(input logic [15:0] a, input logic [15:0] b,
                                              input bit half);
    int ra, ga, ba, rb, gb, bb;
    int r, g, bl;
    ra = a[15:11]; ga = a[10:5]; ba = a[4:0];
    rb = b[15:11]; gb = b[10:5]; bb = b[4:0];
    if (active_mode == BLEND_VENDOR_A) begin
      if (half) begin
        r  = ((ra + rb) * 33) / 8;
        bl = ((ba + bb) * 33) / 8;
        g  = vendor_green(scale6(ga), scale6(gb), 128);
      end else begin
        r  = ((2 * ra + rb) * 22) / 8;
        bl = ((2 * ba + bb) * 22) / 8;
        g  = vendor_green(scale6(ga), scale6(gb), 80);
      end
    end else begin
      r  = blend8(scale5(ra), scale5(rb), half);
      g  = blend8(scale6(ga), scale6(gb), half);
      bl = blend8(scale5(ba), scale5(bb), half);
    end
    return {ALPHA_OPAQUE, 8'(bl), 8'(g), 8'(r)};
  endfunction

  function automatic logic [31:0] endpoint_color(input logic [15:0] c);
    return {ALPHA_OPAQUE, 8'(scale5(c[4:0])), 8'(scale6(c[10:5])), 8'(scale5(c[15:11]))};
  endfunction

  function automatic palette_t predict_palette(input logic [15:0] lo, input logic [15:0] hi,
                                               input logic allow);
    palette_t p;
    p.three_color = allow && (hi >= lo);
    p.entry0 = endpoint_color(lo);
    p.entry1 = endpoint_color(hi);
    if (p.three_color) begin
      p.entry2 = blend_color(lo, hi, 1'b1);
      p.entry3 = '0;
    end else begin
      p.entry2 = blend_color(lo, hi, 1'b0);
      p.entry3 = blend_color(hi, lo, 1'b0);
    end
    return p;
  endfunction

  // ----------------------------------------------------------------- checking
  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %08h want %08h", name, got, want));
  endtask

  always @(posedge clk) begin : track_palettes
    palette_t want;
    if (rst_n && in_tvalid && in_tready)
      palettes_owed.push_back(predict_palette(in_tdata[15:0], in_tdata[31:16], in_tuser));
    if (rst_n && out_tvalid && out_tready) begin
      if (palettes_owed.size() == 0) begin
        report_mismatch("palette out with none owed");
      end else begin
        want = palettes_owed.pop_front();
        check_field("entry zero", out_tdata[31:0], want.entry0);
        check_field("entry one", out_tdata[63:32], want.entry1);
        check_field("entry two", out_tdata[95:64], want.entry2);
        check_field("entry three", out_tdata[127:96], want.entry3);
        check_field("three_color_used", 32'(out_tuser), 32'(want.three_color));
      end
    end
  end

  // output side: random idle, or a counted stall when one is requested
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ------------------------------------------------------------------ drivers
  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_pair(input logic [15:0] lo, input logic [15:0] hi, input logic allow);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {hi, lo};
    in_tuser  <= allow;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_random_pair();
    logic [15:0] lo;
    logic [15:0] hi;
    int kind;
    lo   = 16'($urandom_range(0, 65535));
    hi   = 16'($urandom_range(0, 65535));
    kind = $urandom_range(9);
    if (kind >= 8) hi = lo;
    else if (kind >= 6) hi = lo + 16'($urandom_range(0, 6)) - 16'd3;
    send_pair(lo, hi, 1'($urandom_range(1)));
  endtask

  // hold the input low until every owed palette has come back
  task automatic drain_palettes();
    in_tvalid <= 1'b0;
    while (palettes_owed.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_blend_mode(input logic [1:0] mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    active_mode = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // -------------------------------------------------------------------- tests
  // endpoint extremes, equal and swapped pairs, in every mode; the first
  // pass runs on the reset value of the mode register
  task automatic test_directed_extremes();
    logic [1:0] modes[4];
    modes = '{BLEND_EXACT, BLEND_EXACT_RND, BLEND_VENDOR_A, BLEND_VENDOR_B};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (modes[i]) begin
      if (i != 0) write_blend_mode(modes[i]);
      send_pair(16'h0000, 16'h0000, 1'b1);
      send_pair(16'hFFFF, 16'hFFFF, 1'b0);
      send_pair(16'h0000, 16'hFFFF, 1'b1);
      send_pair(16'hFFFF, 16'h0000, 1'b1);
      send_pair(16'hF800, 16'h07E0, 1'b0);
      send_pair(16'h001F, 16'h001F, 1'b1);
      drain_palettes();
    end
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int per_mode);
    logic [1:0] modes[4];
    modes = '{BLEND_VENDOR_B, BLEND_EXACT, BLEND_VENDOR_A, BLEND_EXACT_RND};
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    foreach (modes[i]) begin
      write_blend_mode(modes[i]);
      repeat (per_mode) send_random_pair();
      drain_palettes();
    end
  endtask

  // stall the output long enough that the block backs up into in_tready
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_blend_mode(BLEND_VENDOR_A);
    stall_left = 80;
    repeat (24) send_random_pair();
    drain_palettes();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_extremes();
    test_random_traffic(11, 52, 100);
    test_output_stall();
    test_random_traffic(52, 11, 100);
    test_random_traffic(0, 0, 100);

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TIMEOUT waiting for the stream to finish");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/bc1pi_pkg.sv
sv/bc1pi_entry_blend.sv
sv/bc1pi_palette.sv
sv/bc1_palette_interpolator_top.sv
sv/bc1pi_checker.sv
tb/tb_bc1_palette_interpolator_top.sv
